@@ rtl/nds_pkg.sv @@
// Package of shared types, constants and helper functions for the delimiter block scanner.
package nds_pkg;

   // Token storage limits, fixed by the 64-bit token registers.
   localparam int MAX_TOKEN_BYTES = 8;
   localparam int TOKEN_BITS      = 64;
   localparam int LENGTH_BITS     = 4;
   localparam int INDEX_BITS      = 4;
   localparam int RESULT_BITS     = 32;

   // Default widths of the scanner state.
   localparam int DEFAULT_OFFSET_BITS = 32;
   localparam int DEFAULT_DEPTH_BITS  = 16;

   // Queue between the classifier and the scanner core.
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_BITS  = 2;
   localparam int QUEUE_CNT_BITS  = 3;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_OPEN_TOKEN   = 2'd0,
      CSR_OPEN_LENGTH  = 2'd1,
      CSR_CLOSE_TOKEN  = 2'd2,
      CSR_CLOSE_LENGTH = 2'd3
   } csr_index_type;

   // One classified item: per-position byte hits against both tokens.
   typedef struct packed {
      logic                       new_stream;
      logic [MAX_TOKEN_BYTES-1:0] open_hit;
      logic [MAX_TOKEN_BYTES-1:0] close_hit;
   } entry_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // A length of zero acts as one; lengths above the limit act as the limit.
   function automatic logic [LENGTH_BITS-1:0] eff_len(input logic [LENGTH_BITS-1:0] len);
      logic [LENGTH_BITS-1:0] result;
      if (len == '0) begin
         result = LENGTH_BITS'(1);
      end else if (len > LENGTH_BITS'(MAX_TOKEN_BYTES)) begin
         result = LENGTH_BITS'(MAX_TOKEN_BYTES);
      end else begin
         result = len;
      end
      return result;
   endfunction

   // Picks the hit bit at a match position.
   function automatic logic hit_at(input logic [MAX_TOKEN_BYTES-1:0] vec,
                                   input logic [INDEX_BITS-1:0] idx);
      logic result;
      result = 1'b0;
      for (int k = 0; k < MAX_TOKEN_BYTES; k++) begin
         if (idx == INDEX_BITS'(k)) begin
            result = vec[k];
         end
      end
      return result;
   endfunction

endpackage

@@ rtl/nested_delimiter_block_scanner.sv @@
// Top level of the nested delimiter block scanner: configuration registers and wiring.
//
// The req_ channel carries one text byte per item, with req_new_stream set on the
// first byte of a stream to clear the offset, depth and match state. The rsp_ channel
// carries one item per outermost block that closes: the offset just past its start
// token and the offset of the first byte of its end token. The csr_ port writes the
// start and end tokens and their lengths; the user must write it only while the block
// is idle, which the block itself does not enforce. Both channels take an item on a
// clock edge with valid high and stall low. Throughput is one byte per cycle while
// rsp_stall holds no result: the scanner core retires one queued byte per cycle
// through a single update of its match indexes, depth and offset counters. A byte
// is queued, scanned when popped, and any result is shown from the result register.
// A four-entry queue parts the byte comparators from the core; while rsp_stall holds
// the result, the core stops and the queue fills, and req_stall rises once it is full.
// Synchronous reset empties the queue and result register, clears the scan state and
// sets both tokens to zero and both lengths to one.
module nested_delimiter_block_scanner #(
   parameter int OFFSET_BITS = nds_pkg::DEFAULT_OFFSET_BITS,
   parameter int DEPTH_BITS  = nds_pkg::DEFAULT_DEPTH_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_new_stream,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [nds_pkg::RESULT_BITS-1:0]   rsp_content_begin,
   output logic [nds_pkg::RESULT_BITS-1:0]   rsp_content_end,
   input  logic                              csr_write_enable,
   input  logic [1:0]                        csr_index,
   input  logic [nds_pkg::TOKEN_BITS-1:0]    csr_write_data
);

   logic [nds_pkg::TOKEN_BITS-1:0]   open_token_ff;
   logic [nds_pkg::TOKEN_BITS-1:0]   close_token_ff;
   logic [nds_pkg::LENGTH_BITS-1:0]  open_length_ff;
   logic [nds_pkg::LENGTH_BITS-1:0]  close_length_ff;

   nds_pkg::queue_status_type        queue_status;
   nds_pkg::entry_type               push_entry;
   nds_pkg::entry_type               head_entry;
   logic                             push;
   logic                             pop;

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_token_ff   <= '0;
         open_length_ff  <= nds_pkg::LENGTH_BITS'(1);
         close_token_ff  <= '0;
         close_length_ff <= nds_pkg::LENGTH_BITS'(1);
      end else if (csr_write_enable) begin
         unique case (nds_pkg::csr_index_type'(csr_index))
            nds_pkg::CSR_OPEN_TOKEN: begin
               open_token_ff <= csr_write_data;
            end
            nds_pkg::CSR_OPEN_LENGTH: begin
               open_length_ff <= csr_write_data[nds_pkg::LENGTH_BITS-1:0];
            end
            nds_pkg::CSR_CLOSE_TOKEN: begin
               close_token_ff <= csr_write_data;
            end
            nds_pkg::CSR_CLOSE_LENGTH: begin
               close_length_ff <= csr_write_data[nds_pkg::LENGTH_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   nds_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_new_stream (req_new_stream),
      .open_token     (open_token_ff),
      .close_token    (close_token_ff),
      .queue_status   (queue_status),
      .push           (push),
      .entry          (push_entry)
   );

   nds_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   nds_back #(
      .OFFSET_BITS (OFFSET_BITS),
      .DEPTH_BITS  (DEPTH_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_entry        (head_entry),
      .queue_status      (queue_status),
      .pop               (pop),
      .open_length       (open_length_ff),
      .close_length      (close_length_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_content_begin (rsp_content_begin),
      .rsp_content_end   (rsp_content_end)
   );

endmodule

@@ rtl/nds_front.sv @@
// Front end: accepts input items and compares each byte against every token position.
module nds_front (
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [7:0]                        req_data_byte,
   input  logic                              req_new_stream,
   input  logic [nds_pkg::TOKEN_BITS-1:0]    open_token,
   input  logic [nds_pkg::TOKEN_BITS-1:0]    close_token,
   input  nds_pkg::queue_status_type         queue_status,
   output logic                              push,
   output nds_pkg::entry_type                entry
);

   // Stall while the queue has no free slot.
   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full;

   // Byte compares against each position of both tokens.
   always_comb begin
      entry.new_stream = req_new_stream;
      for (int k = 0; k < nds_pkg::MAX_TOKEN_BYTES; k++) begin
         entry.open_hit[k]  = (req_data_byte == open_token[8*k +: 8]);
         entry.close_hit[k] = (req_data_byte == close_token[8*k +: 8]);
      end
   end

endmodule

@@ rtl/nds_queue.sv @@
// Short queue of classified items between the front end and the scanner core.
module nds_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  nds_pkg::entry_type         push_entry,
   input  logic                       pop,
   output nds_pkg::entry_type         head_entry,
   output nds_pkg::queue_status_type  status
);

   nds_pkg::entry_type                    slots_ff [nds_pkg::QUEUE_DEPTH];
   logic [nds_pkg::QUEUE_PTR_BITS-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [nds_pkg::QUEUE_PTR_BITS-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [nds_pkg::QUEUE_CNT_BITS-1:0]    count_ff, count_in;

   // Status comes straight from the fill count.
   assign status.full  = (count_ff == nds_pkg::QUEUE_CNT_BITS'(nds_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_entry   = slots_ff[rd_ptr_ff];

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full) else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0) else $error("queue read while empty");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= nds_pkg::QUEUE_CNT_BITS'(nds_pkg::QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

@@ rtl/nds_back.sv @@
// Scanner core: tracks match positions, nesting depth and offsets, and holds the result.
module nds_back #(
   parameter int OFFSET_BITS = nds_pkg::DEFAULT_OFFSET_BITS,
   parameter int DEPTH_BITS  = nds_pkg::DEFAULT_DEPTH_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  nds_pkg::entry_type                  head_entry,
   input  nds_pkg::queue_status_type           queue_status,
   output logic                                pop,
   input  logic [nds_pkg::LENGTH_BITS-1:0]     open_length,
   input  logic [nds_pkg::LENGTH_BITS-1:0]     close_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nds_pkg::RESULT_BITS-1:0]     rsp_content_begin,
   output logic [nds_pkg::RESULT_BITS-1:0]     rsp_content_end
);

   localparam logic [DEPTH_BITS-1:0] DepthMax = '1;

   logic [OFFSET_BITS-1:0]          offset_ff, offset_in;
   logic [DEPTH_BITS-1:0]           depth_ff, depth_in;
   logic                            inside_ff, inside_in;
   logic [nds_pkg::INDEX_BITS-1:0]  open_idx_ff, open_idx_in;
   logic [nds_pkg::INDEX_BITS-1:0]  close_idx_ff, close_idx_in;
   logic [OFFSET_BITS-1:0]          saved_ff, saved_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_BITS-1:0]          begin_ff, begin_in;
   logic [OFFSET_BITS-1:0]          end_ff, end_in;

   logic [nds_pkg::LENGTH_BITS-1:0] olen;
   logic [nds_pkg::LENGTH_BITS-1:0] clen;
   logic                            emit;

   assign olen = nds_pkg::eff_len(open_length);
   assign clen = nds_pkg::eff_len(close_length);

   // Take the next item whenever the result register is free or being emptied.
   assign pop = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);

   // Per-byte state update: end token first while inside, then the start token.
   always_comb begin
      logic [OFFSET_BITS-1:0]          off_b;
      logic [DEPTH_BITS-1:0]           dep;
      logic                            ins;
      logic [nds_pkg::INDEX_BITS-1:0]  om;
      logic [nds_pkg::INDEX_BITS-1:0]  cm;
      logic [OFFSET_BITS-1:0]          sav;
      logic [OFFSET_BITS-1:0]          off_n;

      off_b = head_entry.new_stream ? '0 : offset_ff;
      dep   = head_entry.new_stream ? '0 : depth_ff;
      ins   = head_entry.new_stream ? 1'b0 : inside_ff;
      om    = head_entry.new_stream ? '0 : open_idx_ff;
      cm    = head_entry.new_stream ? '0 : close_idx_ff;
      sav   = head_entry.new_stream ? '0 : saved_ff;
      off_n = off_b + 1'b1;
      if (om >= nds_pkg::INDEX_BITS'(olen)) begin
         om = '0;
      end
      if (cm >= nds_pkg::INDEX_BITS'(clen)) begin
         cm = '0;
      end
      emit = 1'b0;

      // End token, tested only inside a block.
      if (ins && nds_pkg::hit_at(head_entry.close_hit, cm)) begin
         cm = cm + 1'b1;
         if (cm == nds_pkg::INDEX_BITS'(clen)) begin
            cm = '0;
            if (dep != '0) begin
               dep = dep - 1'b1;
            end
            if (dep == '0) begin
               emit = 1'b1;
               ins  = 1'b0;
            end
         end
      end else begin
         cm = '0;
      end

      // Start token, skipped when this byte closed the outermost block.
      if (!emit) begin
         if (nds_pkg::hit_at(head_entry.open_hit, om)) begin
            om = om + 1'b1;
            if (om == nds_pkg::INDEX_BITS'(olen)) begin
               om = '0;
               if (!ins) begin
                  ins = 1'b1;
                  sav = off_n;
               end
               if (dep != DepthMax) begin
                  dep = dep + 1'b1;
               end
            end
         end else begin
            om = '0;
         end
      end

      // Result bounds of the closed block.
      begin_in = sav;
      end_in   = off_n - OFFSET_BITS'(clen);
      if (emit) begin
         sav = '0;
      end

      offset_in    = off_n;
      depth_in     = dep;
      inside_in    = ins;
      open_idx_in  = om;
      close_idx_in = cm;
      saved_in     = sav;
   end

   // Result register handshake.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff    <= '0;
         depth_ff     <= '0;
         inside_ff    <= 1'b0;
         open_idx_ff  <= '0;
         close_idx_ff <= '0;
         saved_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            offset_ff    <= offset_in;
            depth_ff     <= depth_in;
            inside_ff    <= inside_in;
            open_idx_ff  <= open_idx_in;
            close_idx_ff <= close_idx_in;
            saved_ff     <= saved_in;
         end
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         begin_ff <= begin_in;
         end_ff   <= end_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_content_begin = nds_pkg::RESULT_BITS'(begin_ff);
   assign rsp_content_end   = nds_pkg::RESULT_BITS'(end_ff);

   a_depth_inside: assert property (@(posedge clock) disable iff (reset)
      inside_ff |-> depth_ff != '0) else $error("inside a block with zero depth");
   a_close_idle: assert property (@(posedge clock) disable iff (reset)
      !inside_ff |-> close_idx_ff == '0) else $error("end match index moved outside a block");
   a_open_range: assert property (@(posedge clock) disable iff (reset)
      open_idx_ff < nds_pkg::INDEX_BITS'(nds_pkg::MAX_TOKEN_BYTES))
      else $error("start match index out of range");
   a_emit_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !pop) else $error("item taken over a held result");

endmodule
